// ===== sv/assert_macros.svh =====
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled during reset
`define SLPG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Antecedent in this cycle, consequent in the next
`define SLPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/slpg_pkg.sv =====
package slpg_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int STEP_WIDTH      = 16;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_OUT
    } slpg_state_t;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } div_stat_t;

endpackage

// ===== sv/slpg_div.sv =====
module slpg_div #(
    parameter int WIDTH = slpg_pkg::COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [2*WIDTH-1:0]     dividend,
    input  logic [WIDTH-1:0]       divisor,
    output logic [WIDTH-1:0]       quotient,
    output slpg_pkg::div_stat_t    stat
);
    import slpg_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    logic [2*WIDTH-1:0] acc_reg;
    logic [2*WIDTH-1:0] acc_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [WIDTH:0]     trial;
    logic [WIDTH:0]     diff;
    logic               ge;
    logic [WIDTH-1:0]   new_rem;

    // restoring divide, one quotient bit per cycle
    always_comb begin
        trial    = {acc_reg[2*WIDTH-1:WIDTH], acc_reg[WIDTH-1]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        new_rem  = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        acc_next = {new_rem, acc_reg[WIDTH-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                acc_reg  <= dividend;
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDTH - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = acc_reg[WIDTH-1:0];
    assign stat.done   = done_reg;
    assign stat.rem_nz = |acc_reg[2*WIDTH-1:WIDTH];

endmodule

// ===== sv/stepped_line_point_generator_top.sv =====
// Stepped line point generator. A load transaction (req_type 0) stores a segment and a
// step size and returns nothing; a tick transaction (req_type 1) returns the
// next point of the active segment (Y on servo1, X on servo2, last on the final point),
// or nothing when no segment is active. The minor coordinate is exact integer math:
// start + floor(d_minor * offset / d_major), with a registered multiply followed by a
// restoring divider that resolves one quotient bit per clock. s_ready stays low from
// the acceptance of a tick until its result is loaded into the output register, so no
// new load or tick is accepted while a tick is being computed. The result sits in an
// output register; if it has not been taken when the next point is ready, the block
// holds until it is.
module stepped_line_point_generator_top #(
    parameter int COORD_WIDTH = slpg_pkg::COORD_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [COORD_WIDTH-1:0]          s_start_x,
    input  logic [COORD_WIDTH-1:0]          s_start_y,
    input  logic [COORD_WIDTH-1:0]          s_end_x,
    input  logic [COORD_WIDTH-1:0]          s_end_y,
    input  logic [slpg_pkg::STEP_WIDTH-1:0] s_step_size,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [COORD_WIDTH-1:0]          m_servo1_position,
    output logic [COORD_WIDTH-1:0]          m_servo2_position,
    output logic                            m_last
);
    import slpg_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int CW = (W > STEP_WIDTH) ? W : STEP_WIDTH;

    slpg_state_t state_reg, state_next;

    logic                  active_reg;
    logic                  major_y_reg;
    logic                  down_reg;
    logic                  minor_neg_reg;
    logic [W-1:0]          now_reg;
    logic [W-1:0]          begin_reg;
    logic [W-1:0]          minor_begin_reg;
    logic [W-1:0]          final_reg;
    logic [W-1:0]          dmaj_reg;
    logic [W-1:0]          dmin_reg;
    logic [STEP_WIDTH-1:0] stride_reg;
    logic [2*W-1:0]        prod_reg;

    logic                  m_valid_reg;
    logic [W-1:0]          servo1_reg;
    logic [W-1:0]          servo2_reg;
    logic                  last_reg;

    logic                  in_ready;
    logic                  div_start;
    logic                  out_load;
    logic                  accept;

    // load decode
    logic [W:0]            dx, dy, dx_abs, dy_abs;
    logic                  ld_major_y;

    // tick datapath
    logic [W-1:0]          offset;
    logic [2*W-1:0]        prod_next;
    logic [W-1:0]          remaining;
    logic                  is_last;
    logic [W-1:0]          minor;
    logic [W-1:0]          quotient;
    div_stat_t             div_stat;

    slpg_div #(
        .WIDTH (W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dmaj_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb begin
        dx         = {1'b0, s_end_x} - {1'b0, s_start_x};
        dy         = {1'b0, s_end_y} - {1'b0, s_start_y};
        dx_abs     = dx[W] ? (~dx + 1'b1) : dx;
        dy_abs     = dy[W] ? (~dy + 1'b1) : dy;
        ld_major_y = (dy_abs > dx_abs);
    end

    always_comb begin
        offset    = down_reg ? (begin_reg - now_reg) : (now_reg - begin_reg);
        prod_next = {{W{1'b0}}, dmin_reg} * {{W{1'b0}}, offset};
        remaining = down_reg ? (now_reg - final_reg) : (final_reg - now_reg);
        is_last   = (CW'(remaining) < CW'(stride_reg));
        if (dmaj_reg == '0) begin
            minor = minor_begin_reg;
        end else if (minor_neg_reg) begin
            minor = minor_begin_reg - quotient - W'(div_stat.rem_nz);
        end else begin
            minor = minor_begin_reg + quotient;
        end
    end

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_req_type == REQ_TICK && active_reg) begin
                    state_next = ST_START;
                end
            end
            ST_START: state_next = ST_DIV;
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:  in_ready  = 1'b1;
            ST_START: div_start = 1'b1;
            ST_OUT:   out_load  = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign accept = s_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (accept && s_req_type == REQ_LOAD) begin
                active_reg      <= 1'b1;
                major_y_reg     <= ld_major_y;
                down_reg        <= ld_major_y ? dy[W] : dx[W];
                minor_neg_reg   <= ld_major_y ? dx[W] : dy[W];
                begin_reg       <= ld_major_y ? s_start_y : s_start_x;
                now_reg         <= ld_major_y ? s_start_y : s_start_x;
                final_reg       <= ld_major_y ? s_end_y : s_end_x;
                minor_begin_reg <= ld_major_y ? s_start_x : s_start_y;
                dmaj_reg        <= ld_major_y ? dy_abs[W-1:0] : dx_abs[W-1:0];
                dmin_reg        <= ld_major_y ? dx_abs[W-1:0] : dy_abs[W-1:0];
                stride_reg      <= (s_step_size == '0) ? STEP_WIDTH'(1) : s_step_size;
            end

            if (accept && s_req_type == REQ_TICK) begin
                prod_reg <= prod_next;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
                servo1_reg  <= major_y_reg ? now_reg : minor;
                servo2_reg  <= major_y_reg ? minor : now_reg;
                last_reg    <= is_last;
                if (is_last) begin
                    active_reg <= 1'b0;
                end else if (down_reg) begin
                    now_reg <= now_reg - W'(stride_reg);
                end else begin
                    now_reg <= now_reg + W'(stride_reg);
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready           = in_ready;
    assign m_valid           = m_valid_reg;
    assign m_servo1_position = servo1_reg;
    assign m_servo2_position = servo2_reg;
    assign m_last            = last_reg;

endmodule

// ===== sv/slpg_checker.sv =====
`include "assert_macros.svh"

module slpg_checker #(
    parameter int COORD_WIDTH = slpg_pkg::COORD_WIDTH_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_req_type,
    input logic [COORD_WIDTH-1:0]          s_start_x,
    input logic [COORD_WIDTH-1:0]          s_start_y,
    input logic [COORD_WIDTH-1:0]          s_end_x,
    input logic [COORD_WIDTH-1:0]          s_end_y,
    input logic [slpg_pkg::STEP_WIDTH-1:0] s_step_size,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [COORD_WIDTH-1:0]          m_servo1_position,
    input logic [COORD_WIDTH-1:0]          m_servo2_position,
    input logic                            m_last
);
    import slpg_pkg::*;

    // stalled result holds
    `SLPG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_servo1_position) && $stable(m_servo2_position) && $stable(m_last), "result changed while stalled")

    // the input is ready again in the cycle after a load transaction is accepted
    `SLPG_ASSERT_NEXT(a_load_fast, aclk, aresetn, s_valid && s_ready && s_req_type == REQ_LOAD, s_ready, "not ready after load")

    // a new result only appears after a busy period
    `SLPG_ASSERT(a_out_after_busy, aclk, aresetn, $rose(m_valid) |-> $past(!s_ready), "result without computation")

endmodule

bind stepped_line_point_generator_top slpg_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_slpg_checker (.*);
